>>> rtl/core/periodic_grid_difference_defines.svh
// Assertion macros for the periodic grid difference block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef PERIODIC_GRID_DIFFERENCE_DEFINES_SVH
`define PERIODIC_GRID_DIFFERENCE_DEFINES_SVH

`ifndef SYNTH
`define PGD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgd check failed");
`define PGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgd check failed");
`else
`define PGD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PGD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/pgd_pkg.sv
// Shared types and constants for the periodic grid difference block.
// No dependencies; the interfaces and every other RTL module use this package.
`default_nettype none

package pgd_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int IDX_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        MODE_FWD_X = 2'd0,
        MODE_BWD_X = 2'd1,
        MODE_FWD_Y = 2'd2,
        MODE_BWD_Y = 2'd3
    } t_pgd_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_INV_SPACING = 3'd1,
        REG_GRID_WIDTH  = 3'd2,
        REG_GRID_HEIGHT = 3'd3,
        REG_WIN_FIRST   = 3'd4,
        REG_WIN_LAST    = 3'd5
    } t_pgd_reg;

    typedef struct packed {
        t_pgd_mode         mode;
        logic [DATA_W-1:0] inv_spacing;
        logic [SIZE_W-1:0] grid_width;
        logic [SIZE_W-1:0] grid_height;
        logic [ROW_W-1:0]  win_first;
        logic [ROW_W-1:0]  win_last;
    } t_pgd_cfg;

    // One pending difference: sign and magnitude of the raw difference plus its position.
    typedef struct packed {
        logic              neg;
        logic [DATA_W-1:0] mag;
        logic [ROW_W-1:0]  row;
        logic [IDX_W-1:0]  col;
    } t_pgd_op;

    typedef struct packed {
        logic    en1;
        logic    en2;
        t_pgd_op op1;
        t_pgd_op op2;
    } t_pgd_entry;

endpackage

`default_nettype wire

>>> rtl/core/pgd_if.sv
// Channel interfaces of the periodic grid difference block: input samples,
// results and configuration writes. Depends on pgd_pkg.
`default_nettype none

interface pgd_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [pgd_pkg::DATA_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface pgd_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [pgd_pkg::DATA_W-1:0] value;
    logic [pgd_pkg::ROW_W-1:0]        out_row;
    logic [pgd_pkg::IDX_W-1:0]        out_col;
    logic                             saturated;
    logic                             last;

    modport source (output valid, output value, output out_row, output out_col,
                    output saturated, output last, input ready);
    modport sink   (input valid, input value, input out_row, input out_col,
                    input saturated, input last, output ready);
endinterface

interface pgd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pgd_pkg::CFG_IDX_W-1:0]    reg_index;
    logic [pgd_pkg::DATA_W-1:0]       data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/periodic_grid_difference.sv
// Top level of the periodic grid difference block: configuration registers,
// front end, queue and back end. Depends on pgd_pkg, pgd_if, pgd_front, pgd_queue, pgd_back.
`default_nettype none

// Samples arrive in raster order, one item per cycle while the queue has room, and each
// gives zero, one or two results: the periodic first difference along x or y, scaled by
// the reciprocal spacing. An item at a wrap position with two results uses the single
// scaling multiplier once for each result, so a long run of such items is taken more
// slowly, and the four-entry queue between the front and the back end absorbs short
// bursts. An accepted item passes the classify register, the queue, the product register
// and the output register before its first result appears. The row stores are not cleared
// after reset; each entry is written by the first row before any read of it counts.
module periodic_grid_difference (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pgd_cfg_if.sink   i_cfg,
    pgd_in_if.sink    i_in,
    pgd_out_if.source o_out
);
    import pgd_pkg::*;

    t_pgd_cfg          r_cfg;
    logic              push;
    t_pgd_entry        entry;
    logic              pop;
    t_pgd_entry        head;
    logic              head_valid;
    logic [QPTR_W:0]   q_level;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= MODE_FWD_X;
            r_cfg.inv_spacing <= DATA_W'(1) << FRAC_BITS;
            r_cfg.grid_width  <= SIZE_W'(MAX_WIDTH);
            r_cfg.grid_height <= SIZE_W'(MAX_HEIGHT);
            r_cfg.win_first   <= '0;
            r_cfg.win_last    <= '1;
        end else if (i_cfg.valid) begin
            unique case (t_pgd_reg'(i_cfg.reg_index))
                REG_MODE:        r_cfg.mode        <= t_pgd_mode'(i_cfg.data[1:0]);
                REG_INV_SPACING: r_cfg.inv_spacing <= i_cfg.data;
                REG_GRID_WIDTH:  r_cfg.grid_width  <= i_cfg.data[SIZE_W-1:0];
                REG_GRID_HEIGHT: r_cfg.grid_height <= i_cfg.data[SIZE_W-1:0];
                REG_WIN_FIRST:   r_cfg.win_first   <= i_cfg.data[ROW_W-1:0];
                REG_WIN_LAST:    r_cfg.win_last    <= i_cfg.data[ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pgd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_in      (i_in),
        .i_q_level (q_level),
        .o_push    (push),
        .o_entry   (entry)
    );

    pgd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_valid (head_valid),
        .o_level (q_level)
    );

    pgd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_inv_spacing (r_cfg.inv_spacing),
        .i_head        (head),
        .i_head_valid  (head_valid),
        .o_pop         (pop),
        .o_out         (o_out)
    );

endmodule

`default_nettype wire

>>> rtl/core/pgd_queue.sv
// Short queue of classified items between the front and the back end.
// Depends on pgd_pkg and the assertion macro header.
`default_nettype none
`include "periodic_grid_difference_defines.svh"

module pgd_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire pgd_pkg::t_pgd_entry  i_entry,
    input  wire logic                 i_pop,
    output pgd_pkg::t_pgd_entry       o_head,
    output logic                      o_valid,
    output logic [pgd_pkg::QPTR_W:0]  o_level
);
    import pgd_pkg::*;

    t_pgd_entry        r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_valid = (r_count != '0);
    assign o_level = r_count;

    `PGD_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push && !i_pop, r_count < (QPTR_W+1)'(QDEPTH))
    `PGD_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0)
    `PGD_ASSERT_IMPL(a_entry_has_work, i_clk, i_rst_n, o_valid, o_head.en1 || o_head.en2)

endmodule

`default_nettype wire

>>> rtl/core/pgd_front.sv
// Front end: accepts samples, keeps the raster counters and the row stores,
// and turns each item into up to two windowed differences. Depends on pgd_pkg and pgd_if.
`default_nettype none

module pgd_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pgd_pkg::t_pgd_cfg    i_cfg,
    pgd_in_if.sink                    i_in,
    input  wire logic [pgd_pkg::QPTR_W:0] i_q_level,
    output logic                      o_push,
    output pgd_pkg::t_pgd_entry       o_entry
);
    import pgd_pkg::*;

    localparam logic [QPTR_W:0] QDEPTH_V = (QPTR_W+1)'(QDEPTH);

    // Raster state
    logic signed [DATA_W-1:0] r_prev;
    logic signed [DATA_W-1:0] r_rstart;
    logic [IDX_W-1:0]         r_col;
    logic [ROW_W-1:0]         r_row;

    // Row stores; never cleared, an entry is always written before a read of it is used.
    logic [DATA_W-1:0] r_prev_row_mem  [MAX_WIDTH];
    logic [DATA_W-1:0] r_first_row_mem [MAX_WIDTH];
    logic [DATA_W-1:0] r_prow_q;
    logic [DATA_W-1:0] r_frow_q;

    // Classify stage
    logic                     r_f_valid;
    logic signed [DATA_W-1:0] r_f_s;
    logic signed [DATA_W-1:0] r_f_prev;
    logic signed [DATA_W-1:0] r_f_rstart;
    logic [IDX_W-1:0]         r_f_col;
    logic [ROW_W-1:0]         r_f_row;
    logic                     r_f_last_c;
    logic                     r_f_last_r;
    t_pgd_mode                r_f_mode;

    logic              accept;
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic              last_c;
    logic              last_r;

    function automatic t_pgd_op make_op(input logic [DATA_W-1:0] m,
                                        input logic [DATA_W-1:0] n,
                                        input logic [ROW_W-1:0]  row,
                                        input logic [IDX_W-1:0]  col);
        logic [DATA_W:0] dp;
        logic [DATA_W:0] dn;
        t_pgd_op         op;
        dp      = {m[DATA_W-1], m} - {n[DATA_W-1], n};
        dn      = {n[DATA_W-1], n} - {m[DATA_W-1], m};
        op.neg  = dp[DATA_W];
        op.mag  = dp[DATA_W] ? dn[DATA_W-1:0] : dp[DATA_W-1:0];
        op.row  = row;
        op.col  = col;
        return op;
    endfunction

    function automatic logic in_window(input logic [ROW_W-1:0] row,
                                       input logic [ROW_W-1:0] first,
                                       input logic [ROW_W-1:0] last);
        return (row >= first) && (row <= last);
    endfunction

    always_comb begin
        if (i_cfg.grid_width < SIZE_W'(2)) begin
            w_eff = SIZE_W'(2);
        end else if (i_cfg.grid_width > SIZE_W'(MAX_WIDTH)) begin
            w_eff = SIZE_W'(MAX_WIDTH);
        end else begin
            w_eff = i_cfg.grid_width;
        end
        if (i_cfg.grid_height < SIZE_W'(2)) begin
            h_eff = SIZE_W'(2);
        end else if (i_cfg.grid_height > SIZE_W'(MAX_HEIGHT)) begin
            h_eff = SIZE_W'(MAX_HEIGHT);
        end else begin
            h_eff = i_cfg.grid_height;
        end
    end

    // A counter at or past the last index counts as the last one.
    assign last_c = SIZE_W'(r_col) >= (w_eff - SIZE_W'(1));
    assign last_r = SIZE_W'(r_row) >= (h_eff - SIZE_W'(1));

    // Credit check: the queue plus the item in the classify stage must fit.
    assign i_in.ready = (i_q_level + (QPTR_W+1)'(r_f_valid)) < QDEPTH_V;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev_row_mem[r_col] <= i_in.sample;
            r_prow_q              <= r_prev_row_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (r_row == '0) begin
                r_first_row_mem[r_col] <= i_in.sample;
            end
            r_frow_q <= r_first_row_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f_s      <= i_in.sample;
            r_f_prev   <= r_prev;
            r_f_rstart <= r_rstart;
            r_f_col    <= r_col;
            r_f_row    <= r_row;
            r_f_last_c <= last_c;
            r_f_last_r <= last_r;
            r_f_mode   <= i_cfg.mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_prev    <= '0;
            r_rstart  <= '0;
            r_col     <= '0;
            r_row     <= '0;
        end else begin
            r_f_valid <= accept;
            if (accept) begin
                r_prev <= i_in.sample;
                if (r_col == '0) begin
                    r_rstart <= i_in.sample;
                end
                if (last_c) begin
                    r_col <= '0;
                    r_row <= last_r ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + IDX_W'(1);
                end
            end
        end
    end

    always_comb begin
        t_pgd_op op1;
        t_pgd_op op2;
        logic    has1;
        logic    has2;
        logic    e1;
        logic    e2;
        unique case (r_f_mode)
            MODE_FWD_X: begin
                has1 = (r_f_col != '0);
                has2 = r_f_last_c;
                op1  = make_op(r_f_s, r_f_prev, r_f_row, r_f_col - IDX_W'(1));
                op2  = make_op(r_f_rstart, r_f_s, r_f_row, r_f_col);
            end
            MODE_BWD_X: begin
                has1 = (r_f_col != '0);
                has2 = r_f_last_c;
                op1  = make_op(r_f_s, r_f_prev, r_f_row, r_f_col);
                op2  = make_op(r_f_rstart, r_f_s, r_f_row, '0);
            end
            MODE_FWD_Y: begin
                has1 = (r_f_row != '0);
                has2 = r_f_last_r;
                op1  = make_op(r_f_s, r_prow_q, r_f_row - ROW_W'(1), r_f_col);
                op2  = make_op(r_frow_q, r_f_s, r_f_row, r_f_col);
            end
            MODE_BWD_Y: begin
                has1 = (r_f_row != '0);
                has2 = r_f_last_r;
                op1  = make_op(r_f_s, r_prow_q, r_f_row, r_f_col);
                op2  = make_op(r_frow_q, r_f_s, '0, r_f_col);
            end
            default: begin
                has1 = 1'b0;
                has2 = 1'b0;
                op1  = '0;
                op2  = '0;
            end
        endcase
        e1 = has1 && in_window(op1.row, i_cfg.win_first, i_cfg.win_last);
        e2 = has2 && in_window(op2.row, i_cfg.win_first, i_cfg.win_last);
        o_entry.en1 = e1;
        o_entry.en2 = e2;
        o_entry.op1 = op1;
        o_entry.op2 = op2;
        o_push      = r_f_valid && (e1 || e2);
    end

endmodule

`default_nettype wire

>>> rtl/core/pgd_back.sv
// Back end: takes queued differences one at a time, scales them by the
// reciprocal spacing, rounds down, saturates and drives the result channel.
// Depends on pgd_pkg, pgd_if and the assertion macro header.
`default_nettype none
`include "periodic_grid_difference_defines.svh"

module pgd_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [pgd_pkg::DATA_W-1:0] i_inv_spacing,
    input  wire pgd_pkg::t_pgd_entry  i_head,
    input  wire logic                 i_head_valid,
    output logic                      o_pop,
    pgd_out_if.source                 o_out
);
    import pgd_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int QW     = PROD_W - FRAC_BITS;
    localparam logic [PROD_W-1:0] FRAC_MASK = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);
    localparam logic [QW:0]       NEG_LIMIT = (QW+1)'(1) << (DATA_W - 1);
    localparam logic [QW:0]       POS_LIMIT = NEG_LIMIT - (QW+1)'(1);
    localparam logic [DATA_W-1:0] VAL_MIN   = DATA_W'(1) << (DATA_W - 1);
    localparam logic [DATA_W-1:0] VAL_MAX   = VAL_MIN - DATA_W'(1);

    logic r_half;

    logic              r_p_valid;
    logic [PROD_W-1:0] r_p_prod;
    logic              r_p_neg;
    logic [ROW_W-1:0]  r_p_row;
    logic [IDX_W-1:0]  r_p_col;
    logic              r_p_last;

    logic              r_o_valid;
    logic [DATA_W-1:0] r_o_value;
    logic [ROW_W-1:0]  r_o_row;
    logic [IDX_W-1:0]  r_o_col;
    logic              r_o_sat;
    logic              r_o_last;

    logic              adv_o;
    logic              p_free;
    logic              issue;
    logic              sel2;
    logic              op_last;
    t_pgd_op           op;
    logic [DATA_W-1:0] n_value;
    logic              n_sat;

    assign adv_o   = !r_o_valid || o_out.ready;
    assign p_free  = !r_p_valid || adv_o;
    assign issue   = i_head_valid && p_free;
    // The second difference goes once the first has gone or when there is no first.
    assign sel2    = r_half || !i_head.en1;
    assign op      = sel2 ? i_head.op2 : i_head.op1;
    assign op_last = sel2 || !i_head.en2;
    assign o_pop   = issue && op_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half    <= 1'b0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_half <= !op_last;
            end
            if (p_free) begin
                r_p_valid <= issue;
            end
            if (adv_o) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue && p_free) begin
            r_p_prod <= PROD_W'(op.mag) * PROD_W'(i_inv_spacing);
            r_p_neg  <= op.neg;
            r_p_row  <= op.row;
            r_p_col  <= op.col;
            r_p_last <= op_last;
        end
    end

    // Floor of the signed product: a negative magnitude with a fraction rounds up.
    always_comb begin
        logic [QW:0] q;
        q = (QW+1)'(r_p_prod >> FRAC_BITS);
        if (r_p_neg) begin
            q = q + (QW+1)'((r_p_prod & FRAC_MASK) != '0);
            if (q > NEG_LIMIT) begin
                n_sat   = 1'b1;
                n_value = VAL_MIN;
            end else begin
                n_sat   = 1'b0;
                n_value = ~q[DATA_W-1:0] + DATA_W'(1);
            end
        end else begin
            if (q > POS_LIMIT) begin
                n_sat   = 1'b1;
                n_value = VAL_MAX;
            end else begin
                n_sat   = 1'b0;
                n_value = q[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_o && r_p_valid) begin
            r_o_value <= n_value;
            r_o_sat   <= n_sat;
            r_o_row   <= r_p_row;
            r_o_col   <= r_p_col;
            r_o_last  <= r_p_last;
        end
    end

    assign o_out.valid     = r_o_valid;
    assign o_out.value     = r_o_value;
    assign o_out.out_row   = r_o_row;
    assign o_out.out_col   = r_o_col;
    assign o_out.saturated = r_o_sat;
    assign o_out.last      = r_o_last;

    `PGD_ASSERT_IMPL(a_half_needs_second, i_clk, i_rst_n, r_half, i_head_valid && i_head.en2)
    `PGD_ASSERT_IMPL(a_sat_at_limit, i_clk, i_rst_n, r_o_valid && r_o_sat, r_o_value == VAL_MIN || r_o_value == VAL_MAX)
    `PGD_ASSERT_NEXT(a_first_then_second, i_clk, i_rst_n, issue && !op_last, r_half)

endmodule

`default_nettype wire
